@@ hw/rtl/hpsp_pkg.sv @@
// Shared types, character codes and helpers for the patch script parser.
package hpsp_pkg;

  // Default widths of the datapath
  localparam int DEF_ADDRESS_WIDTH = 32;
  localparam int DEF_DEPTH_WIDTH   = 8;
  localparam int DEF_LINE_WIDTH    = 20;
  localparam int DEF_COLUMN_WIDTH  = 16;

  // Token queue between lexer and parser
  localparam int QUEUE_DEPTH = 4;

  // Fixed field widths
  localparam int SYMBOL_WIDTH = 8;
  localparam int BYTE_WIDTH   = 8;
  localparam int KIND_WIDTH   = 2;
  localparam int NIBBLE_WIDTH = 4;

  // ASCII codes the lexer reacts to
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_SEMI    = 8'h3B;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_LBRACK  = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK  = 8'h5D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  // Token kinds passed from lexer to parser
  typedef enum logic [1:0] {
    TOK_DATA  = 2'd0,
    TOK_OPEN  = 2'd1,
    TOK_CLOSE = 2'd2,
    TOK_END   = 2'd3
  } tok_kind_t;

  // Result kinds on the output stream
  typedef enum logic [1:0] {
    RES_WRITE    = 2'd0,
    RES_NO_INSTR = 2'd1,
    RES_NO_CLOSE = 2'd2,
    RES_DONE     = 2'd3
  } res_kind_t;

  // Uppercase hex decode: {valid, value}
  function automatic logic [NIBBLE_WIDTH:0] hex_decode(input logic [7:0] c);
    logic [NIBBLE_WIDTH:0] r;
    r = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, c[3:0]};
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/hex_patch_script_parser.sv @@
// Top level of the patch script parser: lexer, token queue, parser.
// Path: a token from the lexer is stored in the token queue, then the parser loads its result register.
// Throughput: one symbol per cycle; the token queue lets lexer and parser stall separately.
// Output backpressure stalls the parser; input stalls only once the 4-entry queue is full.
// Reset (rst, synchronous, high): line 1, column 0, no comment, no pending digit,
// expecting an open bracket, queue and result register empty.
module hex_patch_script_parser #(
  parameter int ADDRESS_WIDTH = hpsp_pkg::DEF_ADDRESS_WIDTH,
  parameter int DEPTH_WIDTH   = hpsp_pkg::DEF_DEPTH_WIDTH,
  parameter int LINE_WIDTH    = hpsp_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH  = hpsp_pkg::DEF_COLUMN_WIDTH,
  parameter int OUT_W         = ((ADDRESS_WIDTH + 8 + LINE_WIDTH + COLUMN_WIDTH + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hpsp_pkg::SYMBOL_WIDTH-1:0] s_tdata,  // symbol
  input  logic                              s_tlast,  // end_of_text
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // write_address, write_data, error_line, error_column, zero pad
  output logic [OUT_W-1:0]                  m_tdata,
  output logic [hpsp_pkg::KIND_WIDTH-1:0]   m_tuser   // kind
);
  import hpsp_pkg::*;

  localparam int TOK_W = 2 + BYTE_WIDTH + COLUMN_WIDTH + LINE_WIDTH;

  logic             push, full, pop, empty;
  logic [TOK_W-1:0] push_data, pop_data;

  hpsp_front #(
    .DEPTH_WIDTH  (DEPTH_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH),
    .TOK_W        (TOK_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  hpsp_queue #(
    .WIDTH (TOK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  hpsp_back #(
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .LINE_WIDTH    (LINE_WIDTH),
    .COLUMN_WIDTH  (COLUMN_WIDTH),
    .TOK_W         (TOK_W),
    .OUT_W         (OUT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (pop_data),
    .tok_empty (empty),
    .tok_pop   (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

@@ hw/rtl/hpsp_front.sv @@
// Lexer: position tracking, nested comments, hex digit pairing, token push.
module hpsp_front #(
  parameter int DEPTH_WIDTH  = hpsp_pkg::DEF_DEPTH_WIDTH,
  parameter int LINE_WIDTH   = hpsp_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH = hpsp_pkg::DEF_COLUMN_WIDTH,
  parameter int TOK_W        = 2 + 8 + COLUMN_WIDTH + LINE_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hpsp_pkg::SYMBOL_WIDTH-1:0] s_tdata,   // symbol
  input  logic                              s_tlast,   // end_of_text
  output logic                              push,
  output logic [TOK_W-1:0]                  push_data, // kind, value, column, line
  input  logic                              full
);
  import hpsp_pkg::*;

  logic [DEPTH_WIDTH-1:0]  nesting, nesting_next;
  logic [LINE_WIDTH-1:0]   line_num, line_num_next;
  logic [COLUMN_WIDTH-1:0] column, column_next;
  logic                    pend_valid, pend_valid_next;
  logic [NIBBLE_WIDTH-1:0] pend_digit, pend_digit_next;
  logic [COLUMN_WIDTH-1:0] pend_column, pend_column_next;

  logic                    take;
  logic [NIBBLE_WIDTH:0]   hex;
  tok_kind_t               tok_kind;
  logic [BYTE_WIDTH-1:0]   tok_value;
  logic [COLUMN_WIDTH-1:0] tok_column;

  assign s_tready  = !full;
  assign take      = s_tvalid && !full;
  assign hex       = hex_decode(s_tdata);
  assign push_data = {line_num, tok_column, tok_value, tok_kind};

  // Next state and token generation for one accepted symbol
  always_comb begin
    nesting_next     = nesting;
    line_num_next    = line_num;
    column_next      = column;
    pend_valid_next  = pend_valid;
    pend_digit_next  = pend_digit;
    pend_column_next = pend_column;
    push             = 1'b0;
    tok_kind         = TOK_DATA;
    tok_value        = '0;
    tok_column       = column;
    if (take) begin
      if (s_tlast) begin
        // end of script: push an end token, return to reset values
        push             = 1'b1;
        tok_kind         = TOK_END;
        tok_column       = '0;
        nesting_next     = '0;
        line_num_next    = LINE_WIDTH'(1);
        column_next      = '0;
        pend_valid_next  = 1'b0;
        pend_digit_next  = '0;
        pend_column_next = '0;
      end else begin
        // position, saturating
        if (s_tdata == CHAR_NEWLINE) begin
          line_num_next = (line_num == '1) ? line_num : line_num + 1'b1;
          column_next   = '0;
        end else begin
          column_next = (column == '1) ? column : column + 1'b1;
        end
        // comment nesting
        if (s_tdata == CHAR_SEMI) begin
          nesting_next = (nesting == '1) ? nesting : nesting + 1'b1;
        end else if (s_tdata == CHAR_COLON && nesting != '0) begin
          nesting_next = nesting - 1'b1;
        end
        // classification
        if (nesting_next != '0 || !hex[NIBBLE_WIDTH]) begin
          pend_valid_next = 1'b0;
          if (nesting_next == '0 && s_tdata == CHAR_LBRACK) begin
            push     = 1'b1;
            tok_kind = TOK_OPEN;
          end else if (nesting_next == '0 && s_tdata == CHAR_RBRACK) begin
            push     = 1'b1;
            tok_kind = TOK_CLOSE;
          end
        end else if (pend_valid) begin
          pend_valid_next = 1'b0;
          push            = 1'b1;
          tok_kind        = TOK_DATA;
          tok_value       = {pend_digit, hex[NIBBLE_WIDTH-1:0]};
          tok_column      = pend_column;
        end else begin
          pend_valid_next  = 1'b1;
          pend_digit_next  = hex[NIBBLE_WIDTH-1:0];
          pend_column_next = column;
        end
      end
    end
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      nesting     <= '0;
      line_num    <= LINE_WIDTH'(1);
      column      <= '0;
      pend_valid  <= 1'b0;
      pend_digit  <= '0;
      pend_column <= '0;
    end else begin
      nesting     <= nesting_next;
      line_num    <= line_num_next;
      column      <= column_next;
      pend_valid  <= pend_valid_next;
      pend_digit  <= pend_digit_next;
      pend_column <= pend_column_next;
    end
  end

endmodule

@@ hw/rtl/hpsp_queue.sv @@
// Small token FIFO between the lexer and the parser.
module hpsp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = hpsp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/hpsp_back.sv @@
// Parser: command phases, address accumulation, result register.
module hpsp_back #(
  parameter int ADDRESS_WIDTH = hpsp_pkg::DEF_ADDRESS_WIDTH,
  parameter int LINE_WIDTH    = hpsp_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH  = hpsp_pkg::DEF_COLUMN_WIDTH,
  parameter int TOK_W         = 2 + 8 + COLUMN_WIDTH + LINE_WIDTH,
  parameter int OUT_W         = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [TOK_W-1:0]                tok,
  input  logic                            tok_empty,
  output logic                            tok_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_W-1:0]                m_tdata,  // address, data, line, column
  output logic [hpsp_pkg::KIND_WIDTH-1:0] m_tuser   // kind
);
  import hpsp_pkg::*;

  localparam int VAL_LSB  = 2;
  localparam int COL_LSB  = VAL_LSB + BYTE_WIDTH;
  localparam int LINE_LSB = COL_LSB + COLUMN_WIDTH;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_ADDR,
    PH_DATA
  } phase_t;

  phase_t                   phase, phase_next;
  logic [ADDRESS_WIDTH-1:0] addr, addr_next;
  logic                     halted, halted_next;
  logic                     m_tvalid_next;

  tok_kind_t                t_kind;
  logic [BYTE_WIDTH-1:0]    t_value;
  logic [COLUMN_WIDTH-1:0]  t_column;
  logic [LINE_WIDTH-1:0]    t_line;

  logic                     res_load;
  res_kind_t                res_kind;
  logic [ADDRESS_WIDTH-1:0] res_addr;
  logic [BYTE_WIDTH-1:0]    res_data;
  logic [LINE_WIDTH-1:0]    res_line;
  logic [COLUMN_WIDTH-1:0]  res_column;

  assign t_kind   = tok_kind_t'(tok[1:0]);
  assign t_value  = tok[COL_LSB-1:VAL_LSB];
  assign t_column = tok[LINE_LSB-1:COL_LSB];
  assign t_line   = tok[TOK_W-1:LINE_LSB];
  assign tok_pop  = !tok_empty && (!m_tvalid || m_tready);

  // Token interpretation
  always_comb begin
    phase_next  = phase;
    addr_next   = addr;
    halted_next = halted;
    res_load    = 1'b0;
    res_kind    = RES_WRITE;
    res_addr    = '0;
    res_data    = '0;
    res_line    = '0;
    res_column  = '0;
    if (tok_pop) begin
      if (t_kind == TOK_END) begin
        if (!halted) begin
          res_load = 1'b1;
          if (phase == PH_ADDR) begin
            res_kind = RES_NO_CLOSE;
            res_line = t_line;
          end else begin
            res_kind = RES_DONE;
          end
        end
        phase_next  = PH_OPEN;
        addr_next   = '0;
        halted_next = 1'b0;
      end else if (!halted) begin
        case (phase)
          PH_OPEN: begin
            if (t_kind == TOK_OPEN) begin
              phase_next = PH_ADDR;
              addr_next  = '0;
            end else begin
              res_load    = 1'b1;
              res_kind    = RES_NO_INSTR;
              res_line    = t_line;
              res_column  = t_column;
              halted_next = 1'b1;
            end
          end
          PH_ADDR: begin
            if (t_kind == TOK_DATA) begin
              addr_next = (addr << BYTE_WIDTH) | ADDRESS_WIDTH'(t_value);
            end else if (t_kind == TOK_OPEN) begin
              res_load    = 1'b1;
              res_kind    = RES_NO_CLOSE;
              res_line    = t_line;
              res_column  = t_column;
              halted_next = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
          PH_DATA: begin
            if (t_kind == TOK_DATA) begin
              res_load  = 1'b1;
              res_kind  = RES_WRITE;
              res_addr  = addr;
              res_data  = t_value;
              addr_next = addr + 1'b1;
            end else if (t_kind == TOK_OPEN) begin
              phase_next = PH_ADDR;
              addr_next  = '0;
            end else begin
              res_load    = 1'b1;
              res_kind    = RES_NO_INSTR;
              res_line    = t_line;
              res_column  = t_column;
              halted_next = 1'b1;
            end
          end
          default: begin
            phase_next = PH_OPEN;
          end
        endcase
      end
    end
    m_tvalid_next = res_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  // Parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_OPEN;
      addr     <= '0;
      halted   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      phase    <= phase_next;
      addr     <= addr_next;
      halted   <= halted_next;
      m_tvalid <= m_tvalid_next;
    end
    if (res_load) begin
      m_tuser <= res_kind;
      m_tdata <= OUT_W'({res_column, res_line, res_data, res_addr});
    end
  end

endmodule

@@ hw/rtl/hpsp_checker.sv @@
// Port-level checks for the patch script parser, bound to the top level.
module hpsp_checker #(
  parameter int ADDRESS_WIDTH = hpsp_pkg::DEF_ADDRESS_WIDTH,
  parameter int LINE_WIDTH    = hpsp_pkg::DEF_LINE_WIDTH,
  parameter int COLUMN_WIDTH  = hpsp_pkg::DEF_COLUMN_WIDTH,
  parameter int OUT_W         = 80
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [OUT_W-1:0]                m_tdata,
  input logic [hpsp_pkg::KIND_WIDTH-1:0] m_tuser
);
  import hpsp_pkg::*;

  localparam int DATA_LSB = ADDRESS_WIDTH;
  localparam int LINE_LSB = DATA_LSB + BYTE_WIDTH;
  localparam int COL_LSB  = LINE_LSB + LINE_WIDTH;
  localparam int COL_MSB  = COL_LSB + COLUMN_WIDTH - 1;

  // A held result stays put until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Writes carry no position
  a_write_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == RES_WRITE |-> m_tdata[COL_MSB:LINE_LSB] == '0)
    else $error("write result carries a position");

  // Errors carry a line number and no address or data
  a_error_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == RES_NO_INSTR || m_tuser == RES_NO_CLOSE)
    |-> m_tdata[LINE_LSB-1:0] == '0 && m_tdata[COL_LSB-1:LINE_LSB] != '0)
    else $error("malformed error result");

  // Finished result is all zero
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == RES_DONE |-> m_tdata == '0)
    else $error("finished result has nonzero fields");

endmodule

bind hex_patch_script_parser hpsp_checker #(
  .ADDRESS_WIDTH (ADDRESS_WIDTH),
  .LINE_WIDTH    (LINE_WIDTH),
  .COLUMN_WIDTH  (COLUMN_WIDTH),
  .OUT_W         (OUT_W)
) u_hpsp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
